// File: sv/vwbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwbp_pkg
// Shared types and constants of the variable width bit packer.
// ----------------------------------------------------------------------------
package vwbp_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned FWIDTH_W = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PEND_W = 7;   // at most seven leftover bits
  localparam int unsigned PCNT_W = 3;
  localparam int unsigned NBYTE_W = 4;  // 0..8 bytes per request
  localparam int unsigned WORD_W = VALUE_W + PEND_W;

  localparam logic [FWIDTH_W-1:0] MAX_FIELD = 7'd64;

  localparam logic [1:0] CMD_UNSIGNED = 2'd0;
  localparam logic [1:0] CMD_SIGNED   = 2'd1;
  localparam logic [1:0] CMD_FLUSH    = 2'd2;

  // One unit of work for the back end: completed bytes, low byte first.
  typedef struct packed {
    logic [VALUE_W-1:0] word;
    logic [NBYTE_W-1:0] nbytes;
  } job_t;

endpackage
`default_nettype wire

// File: sv/vwbp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwbp_front
// Accepts requests, builds the field, merges it with the leftover bits and
// hands completed bytes, or the leftover bits on a flush, to the job queue.
// ----------------------------------------------------------------------------
module vwbp_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept_i,
  input  wire logic [1:0]                    command_i,
  input  wire logic [vwbp_pkg::VALUE_W-1:0]  value_i,
  input  wire logic [vwbp_pkg::FWIDTH_W-1:0] field_width_i,
  output logic                               q_push_o,
  output vwbp_pkg::job_t                     q_job_o
);

  logic [vwbp_pkg::PEND_W-1:0]   pend_bits_r, pend_bits_nxt;
  logic [vwbp_pkg::PCNT_W-1:0]   pend_cnt_r, pend_cnt_nxt;

  logic [vwbp_pkg::FWIDTH_W-1:0] w_sat;
  logic                          neg;
  logic [vwbp_pkg::VALUE_W-1:0]  mag;
  logic [vwbp_pkg::VALUE_W-1:0]  field;
  logic [vwbp_pkg::VALUE_W-1:0]  mask;
  logic [vwbp_pkg::WORD_W-1:0]   word;
  logic [vwbp_pkg::WORD_W-1:0]   shifted;
  logic [vwbp_pkg::FWIDTH_W-1:0] total;
  logic [vwbp_pkg::NBYTE_W-1:0]  nbytes;

  always_comb begin
    w_sat = (field_width_i > vwbp_pkg::MAX_FIELD) ? vwbp_pkg::MAX_FIELD : field_width_i;
    // sign is bit 63 whatever width; signed stores {v or -v-1, sign bit}
    neg   = value_i[vwbp_pkg::VALUE_W-1];
    mag   = neg ? ~value_i : value_i;
    field = (command_i == vwbp_pkg::CMD_SIGNED) ?
            {mag[vwbp_pkg::VALUE_W-2:0], neg} : value_i;
    mask  = {vwbp_pkg::VALUE_W{1'b1}} >> (vwbp_pkg::MAX_FIELD - w_sat);
    word  = ({{vwbp_pkg::PEND_W{1'b0}}, field & mask} << pend_cnt_r)
          | {{vwbp_pkg::VALUE_W{1'b0}}, pend_bits_r};
    total   = {{(vwbp_pkg::FWIDTH_W-vwbp_pkg::PCNT_W){1'b0}}, pend_cnt_r} + w_sat;
    nbytes  = total[vwbp_pkg::FWIDTH_W-1:3];
    shifted = word >> {nbytes, 3'b000};

    pend_bits_nxt  = pend_bits_r;
    pend_cnt_nxt   = pend_cnt_r;
    q_push_o       = 1'b0;
    q_job_o.word   = word[vwbp_pkg::VALUE_W-1:0];
    q_job_o.nbytes = nbytes;

    if (accept_i) begin
      case (command_i)
        vwbp_pkg::CMD_UNSIGNED, vwbp_pkg::CMD_SIGNED: begin
          if (w_sat != '0) begin
            pend_bits_nxt = shifted[vwbp_pkg::PEND_W-1:0];
            pend_cnt_nxt  = total[vwbp_pkg::PCNT_W-1:0];
            q_push_o      = (nbytes != '0);
          end
        end
        vwbp_pkg::CMD_FLUSH: begin
          q_job_o.word   = {{(vwbp_pkg::VALUE_W-vwbp_pkg::PEND_W){1'b0}}, pend_bits_r};
          q_job_o.nbytes = vwbp_pkg::NBYTE_W'(1);
          q_push_o       = (pend_cnt_r != '0);
          pend_bits_nxt  = '0;
          pend_cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_i && command_i == vwbp_pkg::CMD_FLUSH) |=> (pend_cnt_r == '0 && pend_bits_r == '0))
    else $error("flush left pending bits");

  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_bits_r >> pend_cnt_r) == '0)
    else $error("pending bits above pending count");

endmodule
`default_nettype wire

// File: sv/vwbp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwbp_queue
// Short job queue between the front and the byte emitter.
// ----------------------------------------------------------------------------
module vwbp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire vwbp_pkg::job_t job_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output vwbp_pkg::job_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  vwbp_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    full_o  = (cnt_r == FULL_CNT);
    valid_o = (cnt_r != '0);
    head_o  = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && full_o) && !(pop_i && !valid_o))
    else $error("job queue overflow or underflow");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (job_i.nbytes != '0 && job_i.nbytes <= vwbp_pkg::NBYTE_W'(8)))
    else $error("job with no bytes or too many bytes");

endmodule
`default_nettype wire

// File: sv/vwbp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwbp_back
// Byte emitter: walks the head job one byte per cycle into the output
// register, stalling while a held byte is not popped.
// ----------------------------------------------------------------------------
module vwbp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid_i,
  input  wire vwbp_pkg::job_t              q_job_i,
  output logic                             q_pop_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [vwbp_pkg::BYTE_W-1:0]      byte_o,
  output logic                             last_o
);

  logic [2:0]                  idx_r, idx_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic [vwbp_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                        last_r, last_nxt;
  logic                        load;
  logic                        is_last;

  always_comb begin
    load    = q_valid_i && (!ovalid_r || pop_i);
    is_last = ({1'b0, idx_r} == (q_job_i.nbytes - vwbp_pkg::NBYTE_W'(1)));
    byte_nxt = q_job_i.word[{idx_r, 3'b000} +: vwbp_pkg::BYTE_W];
    last_nxt = is_last;

    q_pop_o    = load && is_last;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    if (load) begin
      idx_nxt    = is_last ? '0 : idx_r + 3'd1;
      ovalid_nxt = 1'b1;
    end else if (pop_i) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign empty_o = !ovalid_r;
  assign byte_o  = byte_r;
  assign last_o  = last_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid_i |-> ({1'b0, idx_r} < q_job_i.nbytes))
    else $error("byte index past end of job");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid_i |-> (idx_r == '0))
    else $error("byte index left mid-job with no job queued");

endmodule
`default_nettype wire

// File: sv/variable_width_bit_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// variable_width_bit_packer
// LSB-first packer of 1..64 bit fields into a byte stream.
// ----------------------------------------------------------------------------
// A request is taken on any cycle in which push is high and full is low; full
// rises only when the job queue (QUEUE_DEPTH entries) holds unfinished work.
// The front end merges the field with up to seven leftover bits without a
// register in between, so requests that complete no byte are taken one per
// cycle while full is low. A request that completes n bytes (n = 1..8) is
// sent by the byte emitter one byte per cycle while pop keeps the output
// register free; the single-byte output port sets the pace of 64-bit fields.
// last_of_run marks the final byte that a request produced.
// ----------------------------------------------------------------------------
module variable_width_bit_packer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    in_command,
  input  wire logic [vwbp_pkg::VALUE_W-1:0]  in_value,
  input  wire logic [vwbp_pkg::FWIDTH_W-1:0] in_field_width,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [vwbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last_of_run
);

  logic           accept;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_valid;
  vwbp_pkg::job_t q_job_in;
  vwbp_pkg::job_t q_head;

  assign accept = push && !q_full;
  assign full   = q_full;

  vwbp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept_i      (accept),
    .command_i     (in_command),
    .value_i       (in_value),
    .field_width_i (in_field_width),
    .q_push_o      (q_push),
    .q_job_o       (q_job_in)
  );

  vwbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  vwbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_job_i   (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop && !empty),
    .empty_o   (empty),
    .byte_o    (out_byte),
    .last_o    (out_last_of_run)
  );

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("outputs not idle after reset");

endmodule
`default_nettype wire
